// File: src/bmf_pkg.sv
// ----------------------------------------------------------------------------
// bmf_pkg
// Shared constants and register codes for the box mean filter.
// ----------------------------------------------------------------------------
package bmf_pkg;

  localparam int PIXEL_W      = 8;
  localparam int COL_SUM_W    = 12;
  localparam int WIN_SUM_W    = 16;
  localparam int FACTOR_SHIFT = 23;
  localparam int FACTOR_W     = FACTOR_SHIFT + 1;
  localparam int DIV_CNT_W    = $clog2(FACTOR_W + 1);
  localparam int DIM_CFG_W    = 11;
  localparam int WIN_CFG_W    = 4;
  localparam int APB_DATA_W   = 32;
  localparam int APB_ADDR_W   = 4;
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_PTR_W   = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W   = $clog2(FIFO_DEPTH + 3);

  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_WINDOW_COLS  = 2'd2,
    REG_WINDOW_ROWS  = 2'd3
  } reg_index_t;

endpackage

// File: src/bmf_ram.sv
// ----------------------------------------------------------------------------
// bmf_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module bmf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: src/box_mean_filter_column_sums_top.sv
// ----------------------------------------------------------------------------
// box_mean_filter_column_sums_top
// Streaming box mean filter: line stores and per-column running sums in RAM,
// sliding horizontal sum in registers, mean by multiply with a reciprocal.
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------
//   pixel in | pix_valid / pix_ready  | pixel
//   result   | res_valid / res_ready  | mean, column, row, frame_last
//   config   | psel/penable/pwrite    | paddr, pwdata, prdata
//
// One pixel per clock while pix_ready is high, via stage 1, stage 2 and the
// result queue. Column sums and line store are read-modify-write RAMs with
// registered reads. After reset and each window size write the reciprocal
// divider runs with pix_ready low. A four-entry result queue absorbs stalls;
// pix_ready also drops when queue plus items in flight would overflow.
// ----------------------------------------------------------------------------
module box_mean_filter_column_sums_top #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024,
  parameter int MAX_WINDOW = 15
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   pix_valid,
  output logic                                   pix_ready,
  input  logic [bmf_pkg::PIXEL_W-1:0]            pixel,
  output logic                                   res_valid,
  input  logic                                   res_ready,
  output logic [bmf_pkg::PIXEL_W-1:0]            mean,
  output logic [$clog2(MAX_WIDTH)-1:0]           column,
  output logic [$clog2(MAX_HEIGHT)-1:0]          row,
  output logic                                   frame_last,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [bmf_pkg::APB_ADDR_W-1:0]         paddr,
  input  logic [bmf_pkg::APB_DATA_W-1:0]         pwdata,
  output logic [bmf_pkg::APB_DATA_W-1:0]         prdata,
  output logic                                   pready
);

  localparam int CW        = $clog2(MAX_WIDTH);
  localparam int RW        = $clog2(MAX_HEIGHT);
  localparam int WIN_LIM   = (MAX_WINDOW % 2 == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;
  localparam int MW        = $clog2(WIN_LIM + 1);
  localparam int LINE_ROWS = WIN_LIM - 1;
  localparam int SW        = $clog2(LINE_ROWS);
  localparam int HW        = $clog2(WIN_LIM);
  localparam int DVW       = $clog2(WIN_LIM * WIN_LIM + 1);
  localparam int LS_DEPTH  = LINE_ROWS * (2 ** CW);

  typedef struct packed {
    logic [bmf_pkg::PIXEL_W-1:0] mean;
    logic [CW-1:0]               column;
    logic [RW-1:0]               row;
    logic                        last;
  } res_entry_t;

  // configuration registers
  logic [bmf_pkg::DIM_CFG_W-1:0] image_width, image_height;
  logic [bmf_pkg::WIN_CFG_W-1:0] window_cols, window_rows;
  logic                          cfg_write;
  logic [1:0]                    cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= bmf_pkg::DIM_CFG_W'(1024);
      image_height <= bmf_pkg::DIM_CFG_W'(1024);
      window_cols  <= bmf_pkg::WIN_CFG_W'(3);
      window_rows  <= bmf_pkg::WIN_CFG_W'(3);
    end else if (cfg_write) begin
      unique case (cfg_index)
        bmf_pkg::REG_IMAGE_WIDTH:  image_width  <= pwdata[bmf_pkg::DIM_CFG_W-1:0];
        bmf_pkg::REG_IMAGE_HEIGHT: image_height <= pwdata[bmf_pkg::DIM_CFG_W-1:0];
        bmf_pkg::REG_WINDOW_COLS:  window_cols  <= pwdata[bmf_pkg::WIN_CFG_W-1:0];
        bmf_pkg::REG_WINDOW_ROWS:  window_rows  <= pwdata[bmf_pkg::WIN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_index)
      bmf_pkg::REG_IMAGE_WIDTH:  prdata = bmf_pkg::APB_DATA_W'(image_width);
      bmf_pkg::REG_IMAGE_HEIGHT: prdata = bmf_pkg::APB_DATA_W'(image_height);
      bmf_pkg::REG_WINDOW_COLS:  prdata = bmf_pkg::APB_DATA_W'(window_cols);
      bmf_pkg::REG_WINDOW_ROWS:  prdata = bmf_pkg::APB_DATA_W'(window_rows);
      default:                   prdata = '0;
    endcase
  end

  // geometry derived from the registers
  logic [CW-1:0]                 cfg_wm1;
  logic [RW-1:0]                 cfg_hm1;
  logic [MW-1:0]                 cfg_m, cfg_n;
  logic [bmf_pkg::WIN_CFG_W-1:0] cols_odd, rows_odd;
  logic [DVW-1:0]                divisor;

  always_comb begin
    if (image_width == '0) begin
      cfg_wm1 = '0;
    end else if (32'(image_width) > MAX_WIDTH) begin
      cfg_wm1 = CW'(MAX_WIDTH - 1);
    end else begin
      cfg_wm1 = CW'(32'(image_width) - 32'd1);
    end
    if (image_height == '0) begin
      cfg_hm1 = '0;
    end else if (32'(image_height) > MAX_HEIGHT) begin
      cfg_hm1 = RW'(MAX_HEIGHT - 1);
    end else begin
      cfg_hm1 = RW'(32'(image_height) - 32'd1);
    end
    cols_odd = window_cols | bmf_pkg::WIN_CFG_W'(1);
    rows_odd = window_rows | bmf_pkg::WIN_CFG_W'(1);
    cfg_m    = (32'(cols_odd) > WIN_LIM) ? MW'(WIN_LIM) : MW'(cols_odd);
    cfg_n    = (32'(rows_odd) > WIN_LIM) ? MW'(WIN_LIM) : MW'(rows_odd);
    divisor  = DVW'(32'(cfg_m) * 32'(cfg_n));
  end

  // reciprocal divider: 2^23 / (m*n), one quotient bit per cycle
  logic                           div_busy;
  logic [bmf_pkg::DIV_CNT_W-1:0]  div_cnt;
  logic [DVW-1:0]                 div_rem;
  logic [bmf_pkg::FACTOR_W-1:0]   div_q;
  logic [DVW:0]                   div_sh;
  logic                           div_start;

  assign div_start = cfg_write && (cfg_index == bmf_pkg::REG_WINDOW_COLS ||
                                   cfg_index == bmf_pkg::REG_WINDOW_ROWS);
  assign div_sh    = {div_rem, (div_cnt == '0)};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b1;
      div_cnt  <= '0;
      div_rem  <= '0;
    end else if (div_start) begin
      div_busy <= 1'b1;
      div_cnt  <= '0;
      div_rem  <= '0;
    end else if (div_busy) begin
      if (div_sh >= {1'b0, divisor}) begin
        div_rem <= DVW'(div_sh - {1'b0, divisor});
        div_q   <= {div_q[bmf_pkg::FACTOR_W-2:0], 1'b1};
      end else begin
        div_rem <= DVW'(div_sh);
        div_q   <= {div_q[bmf_pkg::FACTOR_W-2:0], 1'b0};
      end
      div_cnt <= div_cnt + 1'b1;
      if (32'(div_cnt) == bmf_pkg::FACTOR_W - 1) begin
        div_busy <= 1'b0;
      end
    end
  end

  // stage 0: position, latched geometry, RAM reads
  localparam int FIFO_CNT_W_L = bmf_pkg::FIFO_CNT_W;

  logic [CW-1:0]                col_cnt;
  logic [RW-1:0]                row_cnt;
  logic [HW-1:0]                hslot;
  logic [SW-1:0]                vslot;
  logic [CW-1:0]                lat_wm1, eff_wm1;
  logic [RW-1:0]                lat_hm1, eff_hm1;
  logic [MW-1:0]                lat_m, lat_n, eff_m, eff_n;
  logic [bmf_pkg::FACTOR_W-1:0] lat_factor, eff_factor;
  logic                         frame_start, accept;
  logic                         s1_valid, s2_valid;
  logic [FIFO_CNT_W_L-1:0]      in_flight;
  logic [FIFO_CNT_W_L-1:0]      fifo_cnt;

  assign frame_start = (col_cnt == '0) && (row_cnt == '0);
  assign eff_wm1     = frame_start ? cfg_wm1 : lat_wm1;
  assign eff_hm1     = frame_start ? cfg_hm1 : lat_hm1;
  assign eff_m       = frame_start ? cfg_m : lat_m;
  assign eff_n       = frame_start ? cfg_n : lat_n;
  assign eff_factor  = frame_start ? div_q : lat_factor;
  assign in_flight   = fifo_cnt + FIFO_CNT_W_L'(s1_valid) + FIFO_CNT_W_L'(s2_valid);
  assign pix_ready   = !div_busy && (32'(in_flight) < bmf_pkg::FIFO_DEPTH);
  assign accept      = pix_valid && pix_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
      row_cnt <= '0;
      hslot   <= '0;
      vslot   <= '0;
    end else if (accept) begin
      if (col_cnt == eff_wm1) begin
        col_cnt <= '0;
        hslot   <= '0;
        if (row_cnt == eff_hm1) begin
          row_cnt <= '0;
          vslot   <= '0;
        end else begin
          row_cnt <= row_cnt + 1'b1;
          if (eff_n <= MW'(1) || 32'(vslot) + 32'd2 >= 32'(eff_n)) begin
            vslot <= '0;
          end else begin
            vslot <= vslot + 1'b1;
          end
        end
      end else begin
        col_cnt <= col_cnt + 1'b1;
        if (32'(hslot) + 32'd1 >= 32'(eff_m)) begin
          hslot <= '0;
        end else begin
          hslot <= hslot + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && frame_start) begin
      lat_wm1    <= cfg_wm1;
      lat_hm1    <= cfg_hm1;
      lat_m      <= cfg_m;
      lat_n      <= cfg_n;
      lat_factor <= div_q;
    end
  end

  // stage 1 registers
  logic [bmf_pkg::PIXEL_W-1:0]   s1_pix;
  logic [CW-1:0]                 s1_col, s1_out_col;
  logic [RW-1:0]                 s1_out_row;
  logic [HW-1:0]                 s1_hslot;
  logic [SW-1:0]                 s1_vslot;
  logic                          s1_row_zero, s1_col_zero, s1_vold_en, s1_hold_en;
  logic                          s1_multi, s1_emit, s1_last, s1_fwd;
  logic [bmf_pkg::COL_SUM_W-1:0] s1_fwd_cs;
  logic [bmf_pkg::FACTOR_W-1:0]  s1_factor;
  logic [bmf_pkg::COL_SUM_W-1:0] cs_rdata, cs_rd, cs_base, full_cs, cs_new, full_used;
  logic [bmf_pkg::PIXEL_W-1:0]   ls_rdata, vold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix      <= pixel;
      s1_col      <= col_cnt;
      s1_hslot    <= hslot;
      s1_vslot    <= vslot;
      s1_row_zero <= (row_cnt == '0);
      s1_col_zero <= (col_cnt == '0);
      s1_vold_en  <= (32'(row_cnt) + 32'd1 >= 32'(eff_n));
      s1_hold_en  <= (32'(col_cnt) >= 32'(eff_m));
      s1_multi    <= (eff_n > MW'(1));
      s1_emit     <= (32'(row_cnt) + 32'd1 >= 32'(eff_n)) &&
                     (32'(col_cnt) + 32'd1 >= 32'(eff_m));
      s1_last     <= (row_cnt == eff_hm1) && (col_cnt == eff_wm1);
      s1_out_col  <= CW'(32'(col_cnt) - 32'(eff_m >> 1));
      s1_out_row  <= RW'(32'(row_cnt) - 32'(eff_n >> 1));
      s1_factor   <= eff_factor;
      // same column written in this cycle: RAM returns the old word
      s1_fwd      <= s1_valid && (s1_col == col_cnt);
      s1_fwd_cs   <= cs_new;
    end
  end

  bmf_ram #(
    .WIDTH (bmf_pkg::COL_SUM_W),
    .DEPTH (MAX_WIDTH)
  ) u_col_sums (
    .clk   (clk),
    .we    (s1_valid && s1_multi),
    .waddr (s1_col),
    .wdata (cs_new),
    .raddr (col_cnt),
    .rdata (cs_rdata)
  );

  bmf_ram #(
    .WIDTH (bmf_pkg::PIXEL_W),
    .DEPTH (LS_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (s1_valid && s1_multi),
    .waddr ({s1_vslot, s1_col}),
    .wdata (s1_pix),
    .raddr ({vslot, col_cnt}),
    .rdata (ls_rdata)
  );

  // stage 1: vertical and horizontal running sums
  logic [bmf_pkg::COL_SUM_W-1:0] recent_cs [WIN_LIM];
  logic [bmf_pkg::COL_SUM_W-1:0] hold;
  logic [bmf_pkg::WIN_SUM_W-1:0] window_sum, ws_base, ws_new;

  always_comb begin
    cs_rd     = s1_fwd ? s1_fwd_cs : cs_rdata;
    cs_base   = s1_row_zero ? '0 : cs_rd;
    full_cs   = cs_base + bmf_pkg::COL_SUM_W'(s1_pix);
    vold      = s1_vold_en ? ls_rdata : '0;
    cs_new    = full_cs - bmf_pkg::COL_SUM_W'(vold);
    full_used = s1_multi ? full_cs : bmf_pkg::COL_SUM_W'(s1_pix);
    hold      = s1_hold_en ? recent_cs[s1_hslot] : '0;
    ws_base   = s1_col_zero ? '0 : window_sum;
    ws_new    = ws_base + bmf_pkg::WIN_SUM_W'(full_used) - bmf_pkg::WIN_SUM_W'(hold);
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      window_sum          <= ws_new;
      recent_cs[s1_hslot] <= full_used;
    end
  end

  // stage 2: scale by reciprocal
  logic [bmf_pkg::WIN_SUM_W-1:0]                    s2_ws;
  logic [bmf_pkg::FACTOR_W-1:0]                     s2_factor;
  logic [CW-1:0]                                    s2_col;
  logic [RW-1:0]                                    s2_row;
  logic                                             s2_last;
  logic [bmf_pkg::WIN_SUM_W+bmf_pkg::FACTOR_W-1:0]  prod;
  res_entry_t                                       s2_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      s2_ws     <= ws_new;
      s2_factor <= s1_factor;
      s2_col    <= s1_out_col;
      s2_row    <= s1_out_row;
      s2_last   <= s1_last;
    end
  end

  always_comb begin
    prod            = s2_ws * s2_factor;
    s2_entry.mean   = prod[bmf_pkg::FACTOR_SHIFT +: bmf_pkg::PIXEL_W];
    s2_entry.column = s2_col;
    s2_entry.row    = s2_row;
    s2_entry.last   = s2_last;
  end

  // result queue
  res_entry_t                      fifo_mem [bmf_pkg::FIFO_DEPTH];
  logic [bmf_pkg::FIFO_PTR_W-1:0]  wr_ptr, rd_ptr;
  logic                            pop;

  assign res_valid  = (fifo_cnt != '0);
  assign pop        = res_valid && res_ready;
  assign mean       = fifo_mem[rd_ptr].mean;
  assign column     = fifo_mem[rd_ptr].column;
  assign row        = fifo_mem[rd_ptr].row;
  assign frame_last = fifo_mem[rd_ptr].last;

  always_ff @(posedge clk) begin
    if (s2_valid) begin
      fifo_mem[wr_ptr] <= s2_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= '0;
      rd_ptr   <= '0;
      fifo_cnt <= '0;
    end else begin
      if (s2_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fifo_cnt <= fifo_cnt + FIFO_CNT_W_L'(s2_valid) - FIFO_CNT_W_L'(pop);
    end
  end

endmodule

// File: verif/box_mean_filter_column_sums_top_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// box_mean_filter_column_sums_top_test
// Streams gray frames of many geometries through the box mean filter and
// compares every result against a cycle-free model of the running column and
// window sums kept inside this bench. Covers the reset window, even and zero
// window sizes, clamped dimensions, undersized images, a register write in
// the middle of a frame, a full-width row, a one-pixel-wide column under the
// tallest window, the largest window and random frames, with random idle
// cycles on both sides and a long result stall that backs up the pixel input.
// ----------------------------------------------------------------------------
module box_mean_filter_column_sums_top_test;

  localparam int MAX_WIDTH     = 1024;
  localparam int MAX_HEIGHT    = 1024;
  localparam int MAX_WINDOW    = 15;
  localparam int WINDOW_LIMIT  = (MAX_WINDOW % 2) ? MAX_WINDOW : MAX_WINDOW - 1;
  localparam int LINE_ROWS     = MAX_WINDOW - 1;
  localparam int IDLE_PCT      = 9;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 10;
  localparam int WATCHDOG      = 4000;
  localparam int RANDOM_PIXELS = 120;

  typedef struct packed {
    logic [7:0] mean;
    logic [9:0] column;
    logic [9:0] row;
    logic       frame_last;
  } box_result_t;

  typedef enum {PIX_RANDOM, PIX_BRIGHT, PIX_EXTREME} pixel_mix_t;

  logic                           clk       = 1'b0;
  logic                           rst       = 1'b1;
  logic                           pix_valid = 1'b0;
  logic                           pix_ready;
  logic [bmf_pkg::PIXEL_W-1:0]    pixel     = '0;
  logic                           res_valid;
  logic                           res_ready = 1'b0;
  logic [bmf_pkg::PIXEL_W-1:0]    mean;
  logic [9:0]                     column;
  logic [9:0]                     row;
  logic                           frame_last;
  logic                           psel      = 1'b0;
  logic                           penable   = 1'b0;
  logic                           pwrite    = 1'b0;
  logic [bmf_pkg::APB_ADDR_W-1:0] paddr     = '0;
  logic [bmf_pkg::APB_DATA_W-1:0] pwdata    = '0;
  logic [bmf_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  // shadow registers and latched frame geometry
  logic [10:0] cfg_width  = 11'd1024;
  logic [10:0] cfg_height = 11'd1024;
  logic [3:0]  cfg_cols   = 4'd3;
  logic [3:0]  cfg_rows   = 4'd3;
  int unsigned geo_w, geo_h, geo_cols, geo_rows;
  logic [23:0] geo_factor;

  logic [7:0]  line_store [LINE_ROWS][MAX_WIDTH];
  logic [11:0] col_sum [MAX_WIDTH];
  logic [11:0] recent_col_sum [MAX_WINDOW];
  logic [15:0] win_sum = '0;
  int unsigned next_col = 0;
  int unsigned next_row = 0;

  box_result_t pending_means[$];
  box_result_t want;
  int          error_count = 0;
  int          pixels_sent = 0;
  int          idle_cycles = 0;
  int          stall_left  = 0;
  bit          steady      = 1'b0;
  bit          hold_req    = 1'b0;

  box_mean_filter_column_sums_top DUT (
    .clk        (clk),
    .rst        (rst),
    .pix_valid  (pix_valid),
    .pix_ready  (pix_ready),
    .pixel      (pixel),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .mean       (mean),
    .column     (column),
    .row        (row),
    .frame_last (frame_last),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int unsigned odd_window(input int unsigned v);
    v = (v / 2) * 2 + 1;
    return (v > WINDOW_LIMIT) ? WINDOW_LIMIT : v;
  endfunction

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v < 1) return 1;
    return (v > hi) ? hi : v;
  endfunction

  function automatic int frame_pixels();
    return clamp_dim(cfg_width, MAX_WIDTH) * clamp_dim(cfg_height, MAX_HEIGHT);
  endfunction

  function automatic void advance_box_filter(input logic [7:0] p);
    int unsigned c, r, slot, hslot, full_sum, old_val;
    logic [11:0] full_col;
    logic [63:0] prod;
    box_result_t res;
    if (next_col == 0 && next_row == 0) begin
      geo_w      = clamp_dim(cfg_width, MAX_WIDTH);
      geo_h      = clamp_dim(cfg_height, MAX_HEIGHT);
      geo_cols   = odd_window(cfg_cols);
      geo_rows   = odd_window(cfg_rows);
      geo_factor = 24'((1 << bmf_pkg::FACTOR_SHIFT) / (geo_cols * geo_rows));
    end
    c = (next_col >= geo_w) ? geo_w - 1 : next_col;
    r = (next_row >= geo_h) ? geo_h - 1 : next_row;

    if (geo_rows > 1) begin
      if (r == 0) col_sum[c] = '0;
      full_sum   = col_sum[c] + p;
      slot       = r % (geo_rows - 1);
      old_val    = (r >= geo_rows - 1) ? line_store[slot][c] : 0;
      col_sum[c] = 12'(full_sum - old_val);
      line_store[slot][c] = p;
    end else begin
      full_sum = p;
    end
    full_col = 12'(full_sum);

    if (c == 0) win_sum = '0;
    hslot   = c % geo_cols;
    old_val = (c >= geo_cols) ? recent_col_sum[hslot] : 0;
    win_sum = 16'(win_sum + full_col - old_val);
    recent_col_sum[hslot] = full_col;

    if (r + 1 >= geo_rows && c + 1 >= geo_cols) begin
      prod           = 64'(win_sum) * 64'(geo_factor);
      res.mean       = 8'(prod >> bmf_pkg::FACTOR_SHIFT);
      res.column     = 10'(c - geo_cols / 2);
      res.row        = 10'(r - geo_rows / 2);
      res.frame_last = (r + 1 == geo_h && c + 1 == geo_w);
      pending_means.push_back(res);
    end

    if (c + 1 >= geo_w) begin
      next_col = 0;
      next_row = (r + 1 >= geo_h) ? 0 : r + 1;
    end else begin
      next_col = c + 1;
      next_row = r;
    end
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_v,
                                      input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
      error_count++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) begin
      if (pending_means.size() == 0) begin
        $display("%0t ns: unexpected beat, expected none, actual mean %0d column %0d row %0d",
                 $time, mean, column, row);
        error_count++;
      end else begin
        want = pending_means.pop_front();
        check_field("mean", want.mean, mean);
        check_field("column", want.column, column);
        check_field("row", want.row, row);
        check_field("frame_last", want.frame_last, frame_last);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ready <= 1'b0;
      stall_left--;
    end else if (hold_req) begin
      hold_req = 1'b0;
      stall_left = HOLD_CYCLES;
      res_ready <= 1'b0;
    end else begin
      res_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst || (pix_valid && pix_ready) || (res_valid && res_ready)
        || (psel && penable && pwrite && pready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG) begin
        $display("%0t ns: no beat for %0d cycles", $time, WATCHDOG);
        $display("box_mean_filter_column_sums_top_test: done, errors");
        $finish;
      end
    end
  end

  task automatic send_pixel(input logic [7:0] p);
    @(negedge clk);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      pix_valid <= 1'b0;
      @(negedge clk);
    end
    pix_valid <= 1'b1;
    pixel     <= p;
    @(posedge clk);
    while (!pix_ready) @(posedge clk);
    advance_box_filter(p);
    pixels_sent++;
  endtask

  task automatic send_frame(input int count, input pixel_mix_t mix);
    logic [7:0] p;
    for (int i = 0; i < count; i++) begin
      case (mix)
        PIX_BRIGHT:  p = ($urandom_range(2) != 0) ? 8'hFF : 8'($urandom);
        PIX_EXTREME: p = $urandom_range(1) ? 8'hFF : 8'h00;
        default:     p = 8'($urandom);
      endcase
      send_pixel(p);
    end
  endtask

  // drop valid, let every result drain, then let the pipeline settle
  task automatic quiesce();
    @(negedge clk);
    pix_valid <= 1'b0;
    while (pending_means.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input bmf_pkg::reg_index_t idx, input logic [31:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= bmf_pkg::APB_ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      bmf_pkg::REG_IMAGE_WIDTH:  cfg_width  = value[10:0];
      bmf_pkg::REG_IMAGE_HEIGHT: cfg_height = value[10:0];
      bmf_pkg::REG_WINDOW_COLS:  cfg_cols   = value[3:0];
      bmf_pkg::REG_WINDOW_ROWS:  cfg_rows   = value[3:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_geometry(input logic [31:0] w, input logic [31:0] h,
                              input logic [31:0] cols, input logic [31:0] rows);
    write_reg(bmf_pkg::REG_IMAGE_WIDTH, w);
    write_reg(bmf_pkg::REG_IMAGE_HEIGHT, h);
    write_reg(bmf_pkg::REG_WINDOW_COLS, cols);
    write_reg(bmf_pkg::REG_WINDOW_ROWS, rows);
  endtask

  // window registers left at their reset value
  task automatic test_reset_window();
    write_reg(bmf_pkg::REG_IMAGE_WIDTH, 32'd4);
    write_reg(bmf_pkg::REG_IMAGE_HEIGHT, 32'd3);
    send_frame(frame_pixels(), PIX_EXTREME);
    quiesce();
  endtask

  task automatic test_window_adjust();
    set_geometry(32'd3, 32'd2, 32'd2, 32'd0);
    send_frame(frame_pixels(), PIX_EXTREME);
    quiesce();
  endtask

  task automatic test_undersized_image();
    set_geometry(32'd2, 32'd1, 32'd5, 32'd3);
    send_frame(frame_pixels(), PIX_RANDOM);
    quiesce();
  endtask

  task automatic test_zero_width();
    set_geometry(32'hFFFF_F800, 32'd1, 32'hFFFF_FFF0, 32'd1);
    send_pixel(8'hFF);
    quiesce();
  endtask

  task automatic test_wide_row_backpressure();
    set_geometry(32'd2047, 32'd1, 32'd1, 32'd1);
    hold_req = 1'b1;
    send_frame(frame_pixels(), PIX_RANDOM);
    quiesce();
  endtask

  task automatic test_tall_column();
    set_geometry(32'd1, 32'd64, 32'd1, 32'd15);
    send_frame(frame_pixels(), PIX_RANDOM);
    quiesce();
  endtask

  task automatic test_largest_window();
    set_geometry(32'd20, 32'd16, 32'd14, 32'd15);
    steady = 1'b1;
    send_frame(frame_pixels(), PIX_BRIGHT);
    steady = 1'b0;
    quiesce();
  endtask

  task automatic test_random_frames();
    int unsigned m, n, w, h, cols_val, rows_val, junk;
    int start, total, split;
    bmf_pkg::reg_index_t idx;
    start = pixels_sent;
    while (pixels_sent - start < RANDOM_PIXELS) begin
      cols_val = $urandom_range(15);
      rows_val = $urandom_range(15);
      m = odd_window(cols_val);
      n = odd_window(rows_val);
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(m, 1);
        h = $urandom_range(n, 1);
      end else begin
        w = $urandom_range(m + 8, m);
        h = $urandom_range(n + 5, n);
        while (w * h > 200 && h > n) h--;
      end
      junk = ($urandom_range(3) == 0) ? $urandom : 0;
      set_geometry(w | (junk << 11), h | (junk << 11), cols_val | (junk << 4),
                   rows_val | (junk << 4));
      total = frame_pixels();
      if ((pixels_sent == start || $urandom_range(7) == 0) && total >= 2) begin
        // register write mid-frame: takes effect at the next frame
        split = $urandom_range(total - 1, 1);
        send_frame(split, pixel_mix_t'($urandom_range(2)));
        quiesce();
        idx = bmf_pkg::reg_index_t'($urandom_range(3));
        write_reg(idx, (idx == bmf_pkg::REG_IMAGE_WIDTH ||
                        idx == bmf_pkg::REG_IMAGE_HEIGHT) ?
                  $urandom_range(24, 1) : $urandom_range(15));
        send_frame(total - split, pixel_mix_t'($urandom_range(2)));
      end else begin
        send_frame(total, pixel_mix_t'($urandom_range(2)));
      end
      quiesce();
    end
  endtask

  initial begin
    for (int s = 0; s < LINE_ROWS; s++)
      for (int c = 0; c < MAX_WIDTH; c++)
        line_store[s][c] = '0;
    for (int c = 0; c < MAX_WIDTH; c++) col_sum[c] = '0;
    for (int k = 0; k < MAX_WINDOW; k++) recent_col_sum[k] = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_window();
    test_window_adjust();
    test_undersized_image();
    test_zero_width();
    test_wide_row_backpressure();
    test_tall_column();
    test_largest_window();
    test_random_frames();

    quiesce();
    if (error_count == 0) begin
      $display("box_mean_filter_column_sums_top_test: done, clean");
    end else begin
      $display("box_mean_filter_column_sums_top_test: done, errors");
    end
    $finish;
  end

endmodule
